// ===== rtl/rgra_pkg.sv =====
// ----------------------------------------------------------------------------
// rgra_pkg
// Shared widths, codes and types of the range gated running average.
// ----------------------------------------------------------------------------
package rgra_pkg;

  localparam int unsigned SampleW   = 31;
  localparam int unsigned MinW      = 32;
  localparam int unsigned CountW    = 8;
  localparam int unsigned VerdictW  = 2;
  localparam int unsigned ApbAddrW  = 4;
  localparam int unsigned ApbDataW  = 32;
  localparam int unsigned AvgDivDef = 8;

  localparam logic [SampleW-1:0] LowLimitRst     = '0;
  localparam logic [SampleW-1:0] HighLimitRst    = '1;
  localparam logic [CountW-1:0]  OutlierLimitRst = CountW'(3);

  typedef enum logic [VerdictW-1:0] {
    VERDICT_ACCEPT  = 2'd0,
    VERDICT_OUTLIER = 2'd1,
    VERDICT_RESET   = 2'd2
  } verdict_e;

  typedef enum logic [1:0] {
    REG_LOW_LIMIT     = 2'd0,
    REG_HIGH_LIMIT    = 2'd1,
    REG_OUTLIER_LIMIT = 2'd2
  } reg_idx_e;

  typedef struct packed {
    logic [SampleW-1:0] low_limit;
    logic [SampleW-1:0] high_limit;
    logic [CountW-1:0]  outlier_limit;
  } cfg_t;

  typedef struct packed {
    verdict_e           verdict;
    logic [SampleW-1:0] average;
    logic               average_valid;
    logic [MinW-1:0]    lowest_seen;
    logic [SampleW-1:0] highest_seen;
    logic [SampleW-1:0] last_bad;
  } res_t;

endpackage

// ===== rtl/rgra_if.sv =====
// ----------------------------------------------------------------------------
// rgra_if
// Valid/ready stream channels for samples and results.
// ----------------------------------------------------------------------------
interface rgra_sample_if;
  logic                         valid;
  logic                         ready;
  logic [rgra_pkg::SampleW-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface rgra_result_if;
  logic                          valid;
  logic                          ready;
  logic [rgra_pkg::VerdictW-1:0] verdict;
  logic [rgra_pkg::SampleW-1:0]  average;
  logic                          average_valid;
  logic [rgra_pkg::MinW-1:0]     lowest_seen;
  logic [rgra_pkg::SampleW-1:0]  highest_seen;
  logic [rgra_pkg::SampleW-1:0]  last_bad;

  modport source (output valid, output verdict, output average, output average_valid,
                  output lowest_seen, output highest_seen, output last_bad, input ready);
  modport sink   (input valid, input verdict, input average, input average_valid,
                  input lowest_seen, input highest_seen, input last_bad, output ready);
endinterface

// ===== rtl/rgra_regs.sv =====
// ----------------------------------------------------------------------------
// rgra_regs
// APB register file holding the sample limits and the outlier limit.
// ----------------------------------------------------------------------------
module rgra_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rgra_pkg::ApbAddrW-1:0] paddr,
  input  logic [rgra_pkg::ApbDataW-1:0] pwdata,
  output logic [rgra_pkg::ApbDataW-1:0] prdata,
  output logic                          pready,
  output rgra_pkg::cfg_t                cfg_o
);

  rgra_pkg::cfg_t     cfg_q, cfg_d;
  rgra_pkg::reg_idx_e idx;
  logic               wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = rgra_pkg::reg_idx_e'(paddr[3:2]);

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      unique case (idx)
        rgra_pkg::REG_LOW_LIMIT:     cfg_d.low_limit     = pwdata[rgra_pkg::SampleW-1:0];
        rgra_pkg::REG_HIGH_LIMIT:    cfg_d.high_limit    = pwdata[rgra_pkg::SampleW-1:0];
        rgra_pkg::REG_OUTLIER_LIMIT: cfg_d.outlier_limit = pwdata[rgra_pkg::CountW-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      rgra_pkg::REG_LOW_LIMIT:     prdata = rgra_pkg::ApbDataW'(cfg_q.low_limit);
      rgra_pkg::REG_HIGH_LIMIT:    prdata = rgra_pkg::ApbDataW'(cfg_q.high_limit);
      rgra_pkg::REG_OUTLIER_LIMIT: prdata = rgra_pkg::ApbDataW'(cfg_q.outlier_limit);
      default:                     prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.low_limit     <= rgra_pkg::LowLimitRst;
      cfg_q.high_limit    <= rgra_pkg::HighLimitRst;
      cfg_q.outlier_limit <= rgra_pkg::OutlierLimitRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// ===== rtl/rgra_div.sv =====
// ----------------------------------------------------------------------------
// rgra_div
// Signed division of the sample/average difference by a constant,
// truncated toward zero, via an exact reciprocal multiply on the magnitude.
// ----------------------------------------------------------------------------
module rgra_div #(
  parameter int unsigned AVG_DIV = rgra_pkg::AvgDivDef
) (
  input  logic [rgra_pkg::SampleW:0] diff_i,
  output logic [rgra_pkg::SampleW:0] quot_o
);

  localparam int unsigned DW      = rgra_pkg::SampleW;
  localparam int unsigned DivLog  = $clog2(AVG_DIV);
  localparam int unsigned Shift   = DW + DivLog;
  localparam int unsigned MulW    = DW + 1;
  localparam int unsigned ProdW   = DW + MulW;
  // ceil(2^(DW+log) / d) gives the exact floor for any dividend below 2^DW
  localparam logic [63:0] MulFull = ((64'd1 << Shift) + 64'(AVG_DIV) - 64'd1) / 64'(AVG_DIV);
  localparam logic [MulW-1:0] MulConst = MulFull[MulW-1:0];

  logic             neg;
  logic [DW:0]      mag_full;
  logic [DW-1:0]    mag;
  logic [ProdW-1:0] prod;
  logic [DW-1:0]    q;

  always_comb begin
    neg      = diff_i[DW];
    mag_full = neg ? (~diff_i + 1'b1) : diff_i;
    mag      = mag_full[DW-1:0];
    prod     = ProdW'(mag) * ProdW'(MulConst);
    q        = DW'(prod >> Shift);
    quot_o   = neg ? (~{1'b0, q} + 1'b1) : {1'b0, q};
  end

endmodule

// ===== rtl/rgra_core.sv =====
// ----------------------------------------------------------------------------
// rgra_core
// Average, outlier count and min/max state with the per-sample update logic.
// ----------------------------------------------------------------------------
module rgra_core #(
  parameter int unsigned AVG_DIV = rgra_pkg::AvgDivDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  rgra_pkg::cfg_t               cfg_i,
  input  logic                         step_i,
  input  logic [rgra_pkg::SampleW-1:0] sample_i,
  output rgra_pkg::res_t               res_o
);

  localparam int unsigned SW = rgra_pkg::SampleW;

  logic [SW-1:0]               avg_q, avg_d;
  logic                        valid_q, valid_d;
  logic [rgra_pkg::CountW-1:0] cnt_q, cnt_d, cnt_inc;
  logic [rgra_pkg::MinW-1:0]   min_q, min_d;
  logic [SW-1:0]               max_q, max_d;
  logic [SW-1:0]               bad_q, bad_d;
  logic [SW:0]                 diff, delta, sum;
  logic                        out_of_range;
  rgra_pkg::verdict_e          verdict;

  assign diff = {1'b0, sample_i} - {1'b0, avg_q};

  rgra_div #(.AVG_DIV(AVG_DIV)) u_div (
    .diff_i (diff),
    .quot_o (delta)
  );

  assign sum     = {1'b0, avg_q} + delta;
  assign cnt_inc = cnt_q + 1'b1;

  always_comb begin
    out_of_range = (sample_i < cfg_i.low_limit) || (sample_i > cfg_i.high_limit);
    avg_d   = avg_q;
    valid_d = valid_q;
    cnt_d   = cnt_q;
    bad_d   = bad_q;
    min_d   = ({1'b0, sample_i} < min_q) ? {1'b0, sample_i} : min_q;
    max_d   = (sample_i > max_q) ? sample_i : max_q;
    verdict = rgra_pkg::VERDICT_ACCEPT;
    if (out_of_range) begin
      if (!valid_q) begin
        verdict = rgra_pkg::VERDICT_RESET;
      end else if (cnt_inc >= cfg_i.outlier_limit) begin
        bad_d   = sample_i;
        valid_d = 1'b0;
        cnt_d   = '0;
        verdict = rgra_pkg::VERDICT_RESET;
      end else begin
        cnt_d   = cnt_inc;
        verdict = rgra_pkg::VERDICT_OUTLIER;
      end
    end else begin
      avg_d   = valid_q ? sum[SW-1:0] : sample_i;
      valid_d = 1'b1;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      avg_q   <= '0;
      valid_q <= 1'b0;
      cnt_q   <= '0;
      min_q   <= '1;
      max_q   <= '0;
      bad_q   <= '0;
    end else if (step_i) begin
      avg_q   <= avg_d;
      valid_q <= valid_d;
      cnt_q   <= cnt_d;
      min_q   <= min_d;
      max_q   <= max_d;
      bad_q   <= bad_d;
    end
  end

  always_comb begin
    res_o.verdict       = verdict;
    res_o.average       = avg_d;
    res_o.average_valid = valid_d;
    res_o.lowest_seen   = min_d;
    res_o.highest_seen  = max_d;
    res_o.last_bad      = bad_d;
  end

endmodule

// ===== rtl/range_gated_running_average.sv =====
// ----------------------------------------------------------------------------
// range_gated_running_average
// Running average of a sensor sample stream with range gating, outlier
// counting and min/max tracking.
//
// Samples arrive on in_if, one per transaction; each sample yields exactly
// one result transaction on out_if, in order. Limits and the outlier limit
// are set through the APB port at 0x0, 0x4 and 0x8; the user must write
// them only while idle; the block does not enforce it. A sample lands in the
// input register at acceptance; when the input stage steps it is evaluated
// and written to the result register, which offers it on out_if. Throughput
// is one sample per cycle while out_if does not stall: the state update
// (range compare, subtract, reciprocal multiply for the divide by AVG_DIV,
// add) is combinational from the state registers back to themselves. When
// out_if stalls, the result register holds; the input register still takes
// one more sample, then in_if.ready drops until the result is taken.
// Reset clears the average, the outlier count, min/max and last bad value,
// and loads the register reset values; nothing is offered until a sample.
// ----------------------------------------------------------------------------
module range_gated_running_average #(
  parameter int unsigned AVG_DIV = rgra_pkg::AvgDivDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  rgra_sample_if.sink                   in_if,
  rgra_result_if.source                 out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [rgra_pkg::ApbAddrW-1:0] paddr,
  input  logic [rgra_pkg::ApbDataW-1:0] pwdata,
  output logic [rgra_pkg::ApbDataW-1:0] prdata,
  output logic                          pready
);

  rgra_pkg::cfg_t               cfg;
  rgra_pkg::res_t               res, res_q;
  logic [rgra_pkg::SampleW-1:0] sample_q;
  logic                         in_vld_q, in_vld_d;
  logic                         out_vld_q, out_vld_d;
  logic                         step;

  rgra_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  rgra_core #(.AVG_DIV(AVG_DIV)) u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cfg_i    (cfg),
    .step_i   (step),
    .sample_i (sample_q),
    .res_o    (res)
  );

  // input stage moves on when the result register is free or being drained
  assign step        = in_vld_q && (!out_vld_q || out_if.ready);
  assign in_if.ready = !in_vld_q || step;

  always_comb begin
    in_vld_d  = in_vld_q;
    out_vld_d = out_vld_q;
    if (in_if.ready) begin
      in_vld_d = in_if.valid;
    end
    if (step) begin
      out_vld_d = 1'b1;
    end else if (out_if.ready) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
    end else begin
      in_vld_q  <= in_vld_d;
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_if.valid && in_if.ready) begin
      sample_q <= in_if.sample;
    end
    if (step) begin
      res_q <= res;
    end
  end

  assign out_if.valid         = out_vld_q;
  assign out_if.verdict       = res_q.verdict;
  assign out_if.average       = res_q.average;
  assign out_if.average_valid = res_q.average_valid;
  assign out_if.lowest_seen   = res_q.lowest_seen;
  assign out_if.highest_seen  = res_q.highest_seen;
  assign out_if.last_bad      = res_q.last_bad;

endmodule
